// ===== hdl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo distortion shaper package
// Shared widths, register indexes, configuration struct and output truncation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 20;
   localparam int NUM_LANES   = 2;

   // rational path: numerator/denominator in Q(2F), quotient in Q.F below 2.0
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int QUO_BITS    = FRAC_BITS + 2;
   // foldback path: k - t, its magnitude and the modulus 4t
   localparam int FOLD_BITS   = SAMPLE_BITS + 2;
   localparam int UMAG_BITS   = SAMPLE_BITS + 1;
   localparam int RED_BITS    = PROD_BITS - FRAC_BITS;

   // register stages from request accept to lane result
   localparam int LANE_LAT    = 30;

   localparam int CSR_IDX_BITS = 2;

   localparam logic [PROD_BITS-1:0] ONE_SQ = PROD_BITS'(1) << (2 * FRAC_BITS);
   localparam logic [RED_BITS-1:0]  MAG_POS_MAX = RED_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [RED_BITS-1:0]  MAG_NEG_MAX = RED_BITS'(1 << (SAMPLE_BITS - 1));

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SHAPE_MODE = 2'd0,
      REG_THRESHOLD  = 2'd1,
      REG_GAIN       = 2'd2
   } reg_idx_type;

   typedef enum logic {
      MODE_RATIONAL = 1'b0,
      MODE_FOLDBACK = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [SAMPLE_BITS-1:0]    threshold;
      logic [SAMPLE_BITS-1:0]    gain;
   } cfg_type;

   // drop the fraction bits of a Q(2F) magnitude, saturate, apply the sign
   function automatic sample_type finish_sat(input logic neg,
                                             input logic [PROD_BITS-1:0] prod);
      logic [RED_BITS-1:0] mag;
      logic [RED_BITS-1:0] nmag;
      mag  = prod[PROD_BITS-1:FRAC_BITS];
      nmag = '0;
      if (neg) begin
         if (mag > MAG_NEG_MAX) begin
            mag = MAG_NEG_MAX;
         end
         nmag = RED_BITS'(0) - mag;
         return sample_type'(nmag[SAMPLE_BITS-1:0]);
      end
      if (mag > MAG_POS_MAX) begin
         mag = MAG_POS_MAX;
      end
      return sample_type'(mag[SAMPLE_BITS-1:0]);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sds_rat_div.sv =====
// ----------------------------------------------------------------------------
// Rational quotient divider
// Pipelined restoring divider, one quotient bit per stage, num*2^F / den.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_rat_div (
   input  wire logic                              clock,
   input  wire logic                              ce,
   input  wire logic [sds_pkg::PROD_BITS-1:0]     num_i,
   input  wire logic [sds_pkg::PROD_BITS-1:0]     den_i,
   output logic      [sds_pkg::QUO_BITS-1:0]      quo_o
);
   import sds_pkg::*;

   logic [PROD_BITS-1:0] rem_ff  [QUO_BITS];
   logic [PROD_BITS-1:0] den_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]  bits_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff  [QUO_BITS];

   logic [PROD_BITS-1:0] rem_src  [QUO_BITS];
   logic [PROD_BITS-1:0] den_src  [QUO_BITS];
   logic [QUO_BITS-1:0]  bits_src [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_src  [QUO_BITS];

   genvar s;
   generate
      for (s = 0; s < QUO_BITS; s++) begin : g_stage
         logic [PROD_BITS+1:0] diff_in;
         logic [PROD_BITS:0]   shifted_in;

         if (s == 0) begin : g_first
            // quotient stays below 2^QUO_BITS, so num>>2 is already below den
            assign rem_src[s]  = {2'b00, num_i[PROD_BITS-1:2]};
            assign den_src[s]  = den_i;
            assign bits_src[s] = {num_i[1:0], {(QUO_BITS-2){1'b0}}};
            assign quo_src[s]  = '0;
         end else begin : g_next
            assign rem_src[s]  = rem_ff[s-1];
            assign den_src[s]  = den_ff[s-1];
            assign bits_src[s] = bits_ff[s-1];
            assign quo_src[s]  = quo_ff[s-1];
         end

         assign shifted_in = {rem_src[s], bits_src[s][QUO_BITS-1]};
         assign diff_in    = {1'b0, shifted_in} - {2'b00, den_src[s]};

         always_ff @(posedge clock) begin
            if (ce) begin
               den_ff[s]  <= den_src[s];
               bits_ff[s] <= {bits_src[s][QUO_BITS-2:0], 1'b0};
               if (!diff_in[PROD_BITS+1]) begin
                  rem_ff[s] <= diff_in[PROD_BITS-1:0];
                  quo_ff[s] <= {quo_src[s][QUO_BITS-2:0], 1'b1};
               end else begin
                  rem_ff[s] <= shifted_in[PROD_BITS-1:0];
                  quo_ff[s] <= {quo_src[s][QUO_BITS-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign quo_o = quo_ff[QUO_BITS-1];

endmodule

`default_nettype wire

// ===== hdl/sds_fold_rem.sv =====
// ----------------------------------------------------------------------------
// Foldback remainder unit
// Pipelined restoring remainder |k - t| mod 4t, one dividend bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_fold_rem (
   input  wire logic                              clock,
   input  wire logic                              ce,
   input  wire logic [sds_pkg::UMAG_BITS-1:0]     u_i,
   input  wire logic [sds_pkg::FOLD_BITS-1:0]     d_i,
   output logic      [sds_pkg::FOLD_BITS-1:0]     rem_o
);
   import sds_pkg::*;

   logic [FOLD_BITS-1:0] rem_ff [UMAG_BITS];
   logic [FOLD_BITS-1:0] d_ff   [UMAG_BITS];
   logic [UMAG_BITS-1:0] u_ff   [UMAG_BITS];

   logic [FOLD_BITS-1:0] rem_src [UMAG_BITS];
   logic [FOLD_BITS-1:0] d_src   [UMAG_BITS];
   logic [UMAG_BITS-1:0] u_src   [UMAG_BITS];

   genvar s;
   generate
      for (s = 0; s < UMAG_BITS; s++) begin : g_stage
         logic [FOLD_BITS:0]   shifted_in;
         logic [FOLD_BITS+1:0] diff_in;

         if (s == 0) begin : g_first
            assign rem_src[s] = '0;
            assign d_src[s]   = d_i;
            assign u_src[s]   = u_i;
         end else begin : g_next
            assign rem_src[s] = rem_ff[s-1];
            assign d_src[s]   = d_ff[s-1];
            assign u_src[s]   = u_ff[s-1];
         end

         assign shifted_in = {rem_src[s], u_src[s][UMAG_BITS-1]};
         assign diff_in    = {1'b0, shifted_in} - {2'b00, d_src[s]};

         always_ff @(posedge clock) begin
            if (ce) begin
               d_ff[s] <= d_src[s];
               u_ff[s] <= {u_src[s][UMAG_BITS-2:0], 1'b0};
               if (!diff_in[FOLD_BITS+1]) begin
                  rem_ff[s] <= diff_in[FOLD_BITS-1:0];
               end else begin
                  rem_ff[s] <= shifted_in[FOLD_BITS-1:0];
               end
            end
         end
      end
   endgenerate

   assign rem_o = rem_ff[UMAG_BITS-1];

endmodule

`default_nettype wire

// ===== hdl/sds_lane.sv =====
// ----------------------------------------------------------------------------
// Shaper lane
// Shapes one channel: rational and foldback paths side by side, then the
// mode select, the gain product and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_lane (
   input  wire logic                 clock,
   input  wire logic                 ce,
   input  wire sds_pkg::cfg_type     cfg,
   input  wire sds_pkg::sample_type  sample_i,
   output sds_pkg::sample_type       result_o
);
   import sds_pkg::*;

   localparam int NEG_DLY = QUO_BITS + 3;
   localparam int Q_DLY   = 3;

   // stage 1
   logic [SAMPLE_BITS-1:0]     a_in;
   logic [SAMPLE_BITS:0]       apt_in;
   logic signed [FOLD_BITS-1:0] k_x, t_x, diff_in;
   logic                       fold_in;

   logic [SAMPLE_BITS-1:0]     s1_a_ff;
   logic [SAMPLE_BITS:0]       s1_apt_ff;
   logic                       s1_neg_ff;
   sample_type                 s1_k_ff;
   logic signed [FOLD_BITS-1:0] s1_diff_ff;
   logic                       s1_fold_ff;

   // stage 2
   logic [PROD_BITS:0]         num_in;
   logic signed [FOLD_BITS-1:0] u_in;
   logic [PROD_BITS-1:0]       s2_num_ff;
   logic [SAMPLE_BITS-1:0]     s2_a_ff;
   logic                       s2_neg_ff;
   sample_type                 s2_k_ff;
   logic                       s2_fold_ff;
   logic [UMAG_BITS-1:0]       s2_u_ff;
   logic [FOLD_BITS-1:0]       s2_d_ff;

   // stage 3
   logic [PROD_BITS-1:0]       den_in;
   logic [PROD_BITS-1:0]       s3_num_ff;
   logic [PROD_BITS-1:0]       s3_den_ff;
   logic                       s3_neg_ff;

   logic [QUO_BITS-1:0]        quo;
   logic [FOLD_BITS-1:0]       m;

   logic                       rneg_ff [NEG_DLY];
   logic [QUO_BITS-1:0]        qd_ff   [Q_DLY];
   sample_type                 fk_ff   [UMAG_BITS];
   logic                       ffold_ff[UMAG_BITS];

   // stage 28
   logic signed [FOLD_BITS:0]  e_in, ae_in, vf_in, v_in;
   logic signed [UMAG_BITS-1:0] v_ff;

   // stage 29
   logic [UMAG_BITS-1:0]       vabs_in;
   logic [SAMPLE_BITS-1:0]     mag_in;
   logic                       neg_in;
   logic [PROD_BITS-1:0]       p_ff;
   logic                       pneg_ff;

   sample_type                 res_ff;

   always_comb begin
      a_in    = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : SAMPLE_BITS'(sample_i);
      apt_in  = {1'b0, a_in} + {1'b0, cfg.threshold};
      k_x     = FOLD_BITS'(sample_i);
      t_x     = $signed({2'b00, cfg.threshold});
      diff_in = k_x - t_x;
      fold_in = (k_x >= t_x) || (k_x < -t_x);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_a_ff    <= a_in;
         s1_apt_ff  <= apt_in;
         s1_neg_ff  <= sample_i[SAMPLE_BITS-1];
         s1_k_ff    <= sample_i;
         s1_diff_ff <= diff_in;
         s1_fold_ff <= fold_in;
      end
   end

   always_comb begin
      num_in = PROD_BITS'(s1_a_ff) * (PROD_BITS+1)'(s1_apt_ff);
      u_in   = (s1_diff_ff < 0) ? -s1_diff_ff : s1_diff_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_num_ff  <= num_in[PROD_BITS-1:0];
         s2_a_ff    <= s1_a_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_k_ff    <= s1_k_ff;
         s2_fold_ff <= s1_fold_ff;
         s2_u_ff    <= u_in[UMAG_BITS-1:0];
         s2_d_ff    <= {cfg.threshold, 2'b00};
      end
   end

   // exact denominator is positive, so modular wrap cancels
   assign den_in = s2_num_ff - {4'b0000, s2_a_ff, {FRAC_BITS{1'b0}}} + ONE_SQ;

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_num_ff <= s2_num_ff;
         s3_den_ff <= den_in;
         s3_neg_ff <= s2_neg_ff;
      end
   end

   sds_rat_div u_div (
      .clock (clock),
      .ce    (ce),
      .num_i (s3_num_ff),
      .den_i (s3_den_ff),
      .quo_o (quo)
   );

   sds_fold_rem u_rem (
      .clock (clock),
      .ce    (ce),
      .u_i   (s2_u_ff),
      .d_i   (s2_d_ff),
      .rem_o (m)
   );

   // align sideband with the divider and remainder pipes
   always_ff @(posedge clock) begin
      if (ce) begin
         rneg_ff[0] <= s3_neg_ff;
         for (int i = 1; i < NEG_DLY; i++) begin
            rneg_ff[i] <= rneg_ff[i-1];
         end
         qd_ff[0] <= quo;
         for (int i = 1; i < Q_DLY; i++) begin
            qd_ff[i] <= qd_ff[i-1];
         end
         fk_ff[0]    <= s2_k_ff;
         ffold_ff[0] <= s2_fold_ff;
         for (int i = 1; i < UMAG_BITS; i++) begin
            fk_ff[i]    <= fk_ff[i-1];
            ffold_ff[i] <= ffold_ff[i-1];
         end
      end
   end

   always_comb begin
      e_in  = $signed({1'b0, m}) - $signed({2'b00, cfg.threshold, 1'b0});
      ae_in = (e_in < 0) ? -e_in : e_in;
      vf_in = ae_in - $signed({3'b000, cfg.threshold});
      v_in  = ffold_ff[UMAG_BITS-1] ? vf_in : (FOLD_BITS+1)'(fk_ff[UMAG_BITS-1]);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         v_ff <= v_in[UMAG_BITS-1:0];
      end
   end

   always_comb begin
      vabs_in = v_ff[UMAG_BITS-1] ? UMAG_BITS'(-v_ff) : UMAG_BITS'(v_ff);
      if (cfg.mode == MODE_FOLDBACK) begin
         if (cfg.threshold == '0) begin
            mag_in = '0;
            neg_in = 1'b0;
         end else begin
            mag_in = vabs_in[SAMPLE_BITS-1:0];
            neg_in = v_ff[UMAG_BITS-1];
         end
      end else begin
         mag_in = SAMPLE_BITS'(qd_ff[Q_DLY-1]);
         neg_in = rneg_ff[NEG_DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p_ff    <= PROD_BITS'(mag_in) * PROD_BITS'(cfg.gain);
         pneg_ff <= neg_in;
         res_ff  <= finish_sat(pneg_ff, p_ff);
      end
   end

   assign result_o = res_ff;

endmodule

`default_nettype wire

// ===== hdl/sds_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge and output buffer
// Packs the lane results into one response and holds up to two responses.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_merge (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 vld_i,
   input  wire sds_pkg::sample_type  res_i [sds_pkg::NUM_LANES],
   output logic                      space_o,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // rsp_tdata: left_out [23:0], right_out [47:24]
   output logic [sds_pkg::NUM_LANES*sds_pkg::SAMPLE_BITS-1:0] rsp_tdata
);
   import sds_pkg::*;

   localparam int WORD_BITS = NUM_LANES * SAMPLE_BITS;

   logic [WORD_BITS-1:0] data_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic [WORD_BITS-1:0] word;
   logic                 push, pop;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         word[l*SAMPLE_BITS +: SAMPLE_BITS] = res_i[l];
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign space_o    = (count_ff != 2'd2) || rsp_tready;
   assign push       = vld_i && space_o;
   assign rsp_tdata  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= word;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd2) |-> pop)
      else $error("response pushed into a full buffer");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("buffer count did not follow a push");

endmodule

`default_nettype wire

// ===== hdl/stereo_distortion_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// Stereo distortion shaper
// Rational soft clipper or foldback distortion on one stereo pair per request.
//
// Requests arrive on req_* (left and right Q4.20 samples), responses leave
// on rsp_* (distorted pair, saturated to 24 bits). csr_* writes shape_mode,
// threshold and gain; write them only while no request is in flight.
// Each channel runs in its own lane: a 22-stage restoring divider for the
// rational curve and a 25-stage remainder pipe for the 4t fold, then one
// gain multiply and saturation. Each lane result is registered into the
// output buffer before rsp_tvalid rises. Throughput is one pair per cycle
// while req_tready is high; the divider and remainder pipes take a new pair
// every cycle that the pipeline is not held.
// A two-entry output buffer absorbs receiver stalls; the pipeline keeps
// accepting until the buffer is full, rsp_tready is low and a finished pair
// is waiting at the pipe end; then req_tready drops and everything holds.
// Reset empties the pipeline and buffer and loads mode 0, threshold 0 and
// gain 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_distortion_shaper_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata: left_sample [23:0], right_sample [47:24]
   input  wire logic [sds_pkg::NUM_LANES*sds_pkg::SAMPLE_BITS-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: left_out [23:0], right_out [47:24]
   output logic [sds_pkg::NUM_LANES*sds_pkg::SAMPLE_BITS-1:0] rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [sds_pkg::CSR_IDX_BITS-1:0] csr_addr,
   input  wire logic [sds_pkg::SAMPLE_BITS-1:0]  csr_wdata
);
   import sds_pkg::*;

   cfg_type     cfg_ff;
   logic        vld_ff [LANE_LAT];
   logic        ce;
   logic        space;
   sample_type  res [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_RATIONAL;
         cfg_ff.threshold <= '0;
         cfg_ff.gain      <= SAMPLE_BITS'(1 << FRAC_BITS);
      end else if (csr_wen) begin
         case (reg_idx_type'(csr_addr))
            REG_SHAPE_MODE: cfg_ff.mode      <= mode_type'(csr_wdata[0]);
            REG_THRESHOLD:  cfg_ff.threshold <= csr_wdata;
            REG_GAIN:       cfg_ff.gain      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold the pipe only when a finished pair has nowhere to go
   assign ce         = !vld_ff[LANE_LAT-1] || space;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (ce) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LANE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   genvar l;
   generate
      for (l = 0; l < NUM_LANES; l++) begin : g_lane
         sds_lane u_lane (
            .clock    (clock),
            .ce       (ce),
            .cfg      (cfg_ff),
            .sample_i (sample_type'(req_tdata[l*SAMPLE_BITS +: SAMPLE_BITS])),
            .result_o (res[l])
         );
      end
   endgenerate

   sds_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .vld_i      (vld_ff[LANE_LAT-1]),
      .res_i      (res),
      .space_o    (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== verif/stereo_distortion_shaper_unit_test.sv =====
// ----------------------------------------------------------------------------
// Stereo distortion shaper testbench
// Directed and random stereo pairs across rational and foldback settings,
// with random gaps and stalls on both streams; every response is compared
// against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stereo_distortion_shaper_unit_test;
   import sds_pkg::*;

   localparam int                      CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED  = 2'd3;
   localparam longint                  ONE_Q       = 64'd1 << FRAC_BITS;
   localparam longint                  POS_MAX     = (64'd1 << (SAMPLE_BITS - 1)) - 1;

   typedef struct {
      sample_type left;
      sample_type right;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [NUM_LANES*SAMPLE_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [NUM_LANES*SAMPLE_BITS-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_addr = '0;
   logic [SAMPLE_BITS-1:0] csr_wdata = '0;

   // predictor copy of the settings
   mode_type               cur_mode = MODE_RATIONAL;
   logic [SAMPLE_BITS-1:0] cur_thr  = '0;
   logic [SAMPLE_BITS-1:0] cur_gain = SAMPLE_BITS'(ONE_Q);

   pair_type pending_pairs[$];
   int  error_count = 0;
   int  pairs_sent = 0;
   int  pairs_checked = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   bit  no_gaps = 1'b0;
   bit  rsp_fire = 1'b0;
   int  stall_left = 0;

   stereo_distortion_shaper_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // truncate a Q(2F) magnitude, saturate, apply sign
   function automatic sample_type round_saturate(input bit neg, input longint unsigned prod);
      longint unsigned mag;
      mag = prod >> FRAC_BITS;
      if (neg) begin
         if (mag > POS_MAX + 1) mag = POS_MAX + 1;
         return sample_type'(-mag);
      end
      if (mag > POS_MAX) mag = POS_MAX;
      return sample_type'(mag);
   endfunction

   function automatic sample_type distort_sample(input sample_type k_in);
      longint k, t, a, num, den, q, rem, m, v;
      k = k_in;
      t = cur_thr;
      if (cur_mode == MODE_FOLDBACK) begin
         if (t == 0) return '0;
         if (k >= t || k < -t) begin
            m = (k - t) % (4 * t);
            if (m < 0) m = -m;
            m = m - 2 * t;
            if (m < 0) m = -m;
            v = m - t;
         end else begin
            v = k;
         end
         if (v < 0) return round_saturate(1'b1, (-v) * cur_gain);
         return round_saturate(1'b0, v * cur_gain);
      end
      a = (k < 0) ? -k : k;
      num = a * (a + t);
      den = a * a + t * a - ONE_Q * a + (ONE_Q << FRAC_BITS);
      q = num / den;
      rem = num % den;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      return round_saturate(k < 0, q * cur_gain);
   endfunction

   // sample response handshake between edges; it completes at the next edge
   always @(negedge clock) begin
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pair_type want;
         sample_type got_l, got_r;
         got_l = rsp_tdata[SAMPLE_BITS-1:0];
         got_r = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected response left %0d right %0d", $time, got_l, got_r);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            pairs_checked++;
            if (got_l !== want.left) begin
               $display("%0t: left_out expected %0d actual %0d", $time, want.left, got_l);
               error_count++;
            end
            if (got_r !== want.right) begin
               $display("%0t: right_out expected %0d actual %0d", $time, want.right, got_r);
               error_count++;
            end
         end
      end
   end

   // receiver stalls: fresh draw after each accepted response
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_fire) begin
         stall_left = no_gaps ? 0 : $urandom_range(0, 6);
         rsp_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pair(input sample_type l, input sample_type r);
      pair_type p;
      bit taken;
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r, l};
      p.left = distort_sample(l);
      p.right = distort_sample(r);
      do begin
         @(negedge clock);
         taken = req_tready;
         if (taken) pending_pairs.push_back(p);
         @(posedge clock);
      end while (!taken);
      pairs_sent++;
   endtask

   task automatic drain;
      // drop the last request before waiting so it is not taken again
      req_tvalid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [SAMPLE_BITS-1:0] val);
      drain();
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         REG_SHAPE_MODE: cur_mode = mode_type'(val[0]);
         REG_THRESHOLD:  cur_thr = val;
         REG_GAIN:       cur_gain = val;
         default: ;
      endcase
      settings_used++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return sample_type'(POS_MAX);
         1: return sample_type'(-POS_MAX - 1);
         2: return sample_type'($signed($urandom_range(0, 64)) - 32);
         3: return sample_type'(cur_thr + $urandom_range(0, 4) - 2);
         4: return sample_type'(-$signed({1'b0, cur_thr}) + $urandom_range(0, 4) - 2);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic test_reset_settings;
      send_pair(sample_type'(0), sample_type'(1));
      send_pair(sample_type'(ONE_Q), sample_type'(-ONE_Q));
      send_pair(sample_type'(POS_MAX), sample_type'(-POS_MAX - 1));
      send_pair(sample_type'(-1), sample_type'(ONE_Q / 2));
   endtask

   task automatic test_rational;
      write_reg(REG_THRESHOLD, 24'hFFFFFF);
      write_reg(REG_GAIN, 24'hFFFFFF);
      send_pair(sample_type'(POS_MAX), sample_type'(-POS_MAX - 1));
      send_pair(sample_type'(1), sample_type'(-1));
      send_pair(sample_type'(0), sample_type'(ONE_Q));
      write_reg(REG_GAIN, '0);
      send_pair(sample_type'(ONE_Q), sample_type'(-POS_MAX - 1));
   endtask

   task automatic test_foldback;
      write_reg(REG_SHAPE_MODE, 24'hFFFFFE);   // low bit clear: stays rational
      send_pair(sample_type'(ONE_Q), sample_type'(5));
      write_reg(REG_SHAPE_MODE, 24'h000001);
      write_reg(REG_GAIN, SAMPLE_BITS'(ONE_Q));
      write_reg(REG_THRESHOLD, '0);            // zero threshold gives silence
      send_pair(sample_type'(POS_MAX), sample_type'(-POS_MAX - 1));
      write_reg(REG_THRESHOLD, SAMPLE_BITS'(ONE_Q / 2));
      send_pair(sample_type'(ONE_Q / 2), sample_type'(-ONE_Q / 2));
      send_pair(sample_type'(ONE_Q / 2 - 1), sample_type'(-ONE_Q / 2 - 1));
      send_pair(sample_type'(POS_MAX), sample_type'(-POS_MAX - 1));
      write_reg(REG_THRESHOLD, 24'hFFFFFF);
      write_reg(REG_GAIN, 24'hFFFFFF);         // saturate both ways
      send_pair(sample_type'(POS_MAX), sample_type'(-POS_MAX - 1));
   endtask

   task automatic test_unused_register;
      write_reg(REG_UNUSED, 24'h123456);
      send_pair(sample_type'(ONE_Q), sample_type'(-3));
   endtask

   task automatic test_random_traffic;
      for (int phase = 0; phase < 10; phase++) begin
         write_reg(REG_SHAPE_MODE, SAMPLE_BITS'($urandom_range(0, 1)));
         case (phase % 4)
            0: write_reg(REG_THRESHOLD, '0);
            1: write_reg(REG_THRESHOLD, 24'hFFFFFF);
            default: write_reg(REG_THRESHOLD, SAMPLE_BITS'($urandom_range(1, 1 << 22)));
         endcase
         case (phase % 3)
            0: write_reg(REG_GAIN, 24'hFFFFFF);
            1: write_reg(REG_GAIN, SAMPLE_BITS'($urandom));
            default: write_reg(REG_GAIN, (phase == 2) ? '0 : SAMPLE_BITS'(ONE_Q));
         endcase
         for (int n = 0; n < 200; n++) begin
            // hold back-to-back stretches now and then
            if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_pair(pick_sample(), pick_sample());
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_rational();
      test_foldback();
      test_unused_register();
      test_random_traffic();
      drain();
      repeat (2 * LANE_LAT) @(posedge clock);
      if (pending_pairs.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_pairs.size());
         error_count++;
      end
      $display("Sent %0d stereo pairs, checked %0d responses, %0d register writes.",
               pairs_sent, pairs_checked, settings_used);
      $display("Covered rational and foldback shaping, zero and full threshold and gain.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sds_pkg.sv
hdl/sds_rat_div.sv
hdl/sds_fold_rem.sv
hdl/sds_lane.sv
hdl/sds_merge.sv
hdl/stereo_distortion_shaper_unit.sv
verif/stereo_distortion_shaper_unit_test.sv
